// ----- rtl/core/trigger_timestamp_event_formatter_macros.svh -----
// Assertion macros shared by the trigger timestamp event formatter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TRIGGER_TIMESTAMP_EVENT_FORMATTER_MACROS_SVH
`define TRIGGER_TIMESTAMP_EVENT_FORMATTER_MACROS_SVH

// General form: named check on a clock with a disabling reset
`define TTEF_ASSERT_ON(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Short form on the block clock and reset
`define TTEF_ASSERT(name, prop, msg) \
   `TTEF_ASSERT_ON(name, clock, reset, prop, msg)

`endif

// ----- rtl/core/ttef_pkg.sv -----
// Package for the trigger timestamp event formatter: constants, codes and types.
// Used by ttef_word_out and trigger_timestamp_event_formatter; no dependencies.
package ttef_pkg;

   // number of per-type trigger counters
   localparam int unsigned TYPE_COUNT = 16;
   localparam int unsigned TYPE_IDX_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

   // configuration register indexes
   localparam logic CSR_FIFO_CHANNEL = 1'b0;
   localparam logic CSR_MAX_FILL     = 1'b1;

   // reset values of the configuration registers
   localparam logic [4:0]  FIFO_CHANNEL_RESET = 5'd3;
   localparam logic [15:0] MAX_FILL_RESET     = 16'd1;

   // output words
   localparam logic [31:0] HEADER_WORD = 32'h0000_0600;
   localparam logic [31:0] BAD_WORD    = 32'hbad0_0bad;
   localparam logic [15:0] SLICE_ID [4] = '{16'h03e1, 16'h04e1, 16'h05e1, 16'h06e1};

   // first type that reads no timestamp
   localparam logic [3:0] NO_STAMP_TYPE = 4'd14;

   // word index of the last slice of a good trigger
   localparam logic [2:0] LAST_WORD_IDX = 3'd4;

   typedef enum logic [1:0] {
      KIND_GOOD    = 2'd0,
      KIND_FAULT   = 2'd1,
      KIND_RECOVER = 2'd2
   } kind_type;

   // one trigger's result, handed from the count stage to the word sequencer
   typedef struct packed {
      kind_type    kind;
      logic        back;
      logic [63:0] stamp;
      logic [31:0] type_count;
      logic [31:0] total_count;
      logic [31:0] recovery_count;
   } result_type;

endpackage

// ----- rtl/core/ttef_word_out.sv -----
// Output word sequencer: turns one trigger result into its stream of words.
// Depends on ttef_pkg and the assertion macros header.
`include "trigger_timestamp_event_formatter_macros.svh"

module ttef_word_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   input  ttef_pkg::result_type  load_res,
   output logic                  load_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // data_word [31:0], type_count [63:32], total_count [95:64], recovery_count [127:96]
   output logic [127:0]          rsp_tdata,
   output logic                  rsp_tlast,
   // clear_request [0], time_backwards [1]
   output logic [1:0]            rsp_tuser
);

   logic                 busy_ff, busy_in;
   logic [2:0]           idx_ff, idx_in;
   ttef_pkg::result_type res_ff, res_in;
   logic                 last;
   logic [1:0]           slice_sel;
   logic [31:0]          data_word;

   // last word: every word of a bad trigger, the fourth slice of a good one
   assign last = (res_ff.kind != ttef_pkg::KIND_GOOD) || (idx_ff == ttef_pkg::LAST_WORD_IDX);
   assign load_ready = !busy_ff || (rsp_tready && last);

   // advance through the words, load the next result as the current one leaves
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      res_in  = res_ff;
      if (busy_ff && rsp_tready) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
      if (load_valid && load_ready) begin
         busy_in = 1'b1;
         idx_in  = 3'd0;
         res_in  = load_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      res_ff <= res_in;
   end

   // select the word: header, tagged slice or error marker
   assign slice_sel = 2'(idx_ff - 3'd1);

   always_comb begin
      case (res_ff.kind)
         ttef_pkg::KIND_GOOD: begin
            if (idx_ff == 3'd0) begin
               data_word = ttef_pkg::HEADER_WORD;
            end else begin
               data_word = {ttef_pkg::SLICE_ID[slice_sel], res_ff.stamp[16*slice_sel +: 16]};
            end
         end
         default: data_word = ttef_pkg::BAD_WORD;
      endcase
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {res_ff.recovery_count, res_ff.total_count, res_ff.type_count, data_word};
   assign rsp_tlast  = last;
   assign rsp_tuser  = {(res_ff.kind == ttef_pkg::KIND_GOOD) && res_ff.back,
                        res_ff.kind == ttef_pkg::KIND_RECOVER};

   `TTEF_ASSERT(a_clear_is_last, rsp_tvalid && rsp_tuser[0] |-> rsp_tlast, "clear word not last")
   `TTEF_ASSERT(a_back_not_bad, rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[31:0] != ttef_pkg::BAD_WORD, "backwards flag on error word")
   `TTEF_ASSERT(a_word_walk, busy_ff && rsp_tready && !last && !load_valid |=> busy_ff && idx_ff == $past(idx_ff) + 3'd1, "word index skipped")

endmodule

// ----- rtl/core/trigger_timestamp_event_formatter.sv -----
// Trigger timestamp event formatter, top level.
// A trigger is registered in the count stage, then loaded into the output word sequencer.
// A good trigger gives five words, sent by the output sequencer one word per cycle while
// rsp_tready is high; a fault or recovery gives one word, any other type 14/15 none.
// Per-type counters: a one-port-read memory, read at accept, written as the stage advances.
// Reset (synchronous, active high) clears all counters, error state and stored timestamp.
`include "trigger_timestamp_event_formatter_macros.svh"

module trigger_timestamp_event_formatter (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [15:0]   csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   // ready_mask [31:0], fill_count [47:32], stamp_high [79:48], stamp_low [111:80],
   // stamp_fine [143:112]
   input  logic [143:0]  req_tdata,
   // trig_type [3:0]
   input  logic [3:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // data_word [31:0], type_count [63:32], total_count [95:64], recovery_count [127:96]
   output logic [127:0]  rsp_tdata,
   output logic          rsp_tlast,
   // clear_request [0], time_backwards [1]
   output logic [1:0]    rsp_tuser
);

   localparam int unsigned IW = ttef_pkg::TYPE_IDX_W;

   // configuration registers
   logic [4:0]  fifo_channel_ff;
   logic [15:0] max_fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_channel_ff <= ttef_pkg::FIFO_CHANNEL_RESET;
         max_fill_ff     <= ttef_pkg::MAX_FILL_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ttef_pkg::CSR_FIFO_CHANNEL: fifo_channel_ff <= csr_wdata[4:0];
            ttef_pkg::CSR_MAX_FILL:     max_fill_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // count stage registers
   logic          s1_valid_ff;
   logic [3:0]    s1_type_ff;
   logic [IW-1:0] s1_idx_ff;
   logic [31:0]   s1_ready_ff;
   logic [15:0]   s1_fill_ff;
   logic [63:0]   s1_stamp_ff;
   logic          s1_hit_ff;
   logic [31:0]   s1_fwd_ff;
   logic          s1_vld_ff;
   logic [31:0]   s1_rd_ff;

   // block state
   logic [31:0]   cnt_mem [ttef_pkg::TYPE_COUNT];
   logic [ttef_pkg::TYPE_COUNT-1:0] cnt_valid_ff;
   logic          err_ff, err_in;
   logic [63:0]   prev_ff, prev_in;
   logic [31:0]   total_ff, total_in;
   logic [31:0]   recov_ff, recov_in;

   logic          accept;
   logic [IW-1:0] req_idx;
   logic          s1_type_ok;
   logic [31:0]   s1_count_new;
   logic          s1_emit;
   logic          s1_advance;
   logic          cnt_we;
   logic          load_ready;
   ttef_pkg::result_type load_res;

   assign req_idx    = IW'(req_tuser);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign accept     = req_tvalid && req_tready;

   assign s1_type_ok   = 32'(s1_type_ff) < 32'(ttef_pkg::TYPE_COUNT);
   // take the forwarded value when the previous trigger wrote this counter as it was read
   assign s1_count_new = (s1_hit_ff ? s1_fwd_ff : (s1_vld_ff ? s1_rd_ff : 32'd0)) + 32'd1;
   assign s1_emit      = err_ff || (s1_type_ff < ttef_pkg::NO_STAMP_TYPE);
   assign s1_advance   = s1_valid_ff && (!s1_emit || load_ready);
   assign cnt_we       = s1_advance && s1_type_ok;

   // capture the transaction and read its type counter
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (accept) begin
         s1_type_ff  <= req_tuser;
         s1_idx_ff   <= req_idx;
         s1_ready_ff <= req_tdata[31:0];
         s1_fill_ff  <= req_tdata[47:32];
         s1_stamp_ff <= {req_tdata[76:48], req_tdata[111:80], req_tdata[114:112]};
         s1_hit_ff   <= cnt_we && (s1_idx_ff == req_idx);
         s1_fwd_ff   <= s1_count_new;
         s1_vld_ff   <= cnt_valid_ff[req_idx];
         s1_rd_ff    <= cnt_mem[req_idx];
      end
   end

   // write back the incremented counter
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[s1_idx_ff] <= s1_count_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= '0;
      end else if (cnt_we) begin
         cnt_valid_ff[s1_idx_ff] <= 1'b1;
      end
   end

   // decide the outcome of the trigger and update the block state
   always_comb begin
      err_in   = err_ff;
      prev_in  = prev_ff;
      total_in = total_ff;
      recov_in = recov_ff;
      load_res.kind           = ttef_pkg::KIND_GOOD;
      load_res.back           = prev_ff > s1_stamp_ff;
      load_res.stamp          = s1_stamp_ff;
      load_res.type_count     = s1_type_ok ? s1_count_new : 32'd0;
      load_res.total_count    = total_ff + 32'd1;
      load_res.recovery_count = recov_ff;
      if (err_ff) begin
         load_res.kind           = ttef_pkg::KIND_RECOVER;
         load_res.recovery_count = recov_ff + 32'd1;
      end else if (!s1_ready_ff[fifo_channel_ff] || (s1_fill_ff > max_fill_ff)) begin
         load_res.kind = ttef_pkg::KIND_FAULT;
      end
      if (s1_advance) begin
         total_in = total_ff + 32'd1;
         if (err_ff) begin
            err_in   = 1'b0;
            recov_in = recov_ff + 32'd1;
         end else if (s1_type_ff < ttef_pkg::NO_STAMP_TYPE) begin
            if (load_res.kind == ttef_pkg::KIND_FAULT) begin
               err_in = 1'b1;
            end else begin
               prev_in = s1_stamp_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff   <= 1'b0;
         prev_ff  <= 64'd0;
         total_ff <= 32'd0;
         recov_ff <= 32'd0;
      end else begin
         err_ff   <= err_in;
         prev_ff  <= prev_in;
         total_ff <= total_in;
         recov_ff <= recov_in;
      end
   end

   ttef_word_out u_word_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s1_valid_ff && s1_emit),
      .load_res   (load_res),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   `TTEF_ASSERT(a_accept_fills_stage, accept |=> s1_valid_ff, "accepted transaction lost")
   `TTEF_ASSERT(a_recovery_clears_error, s1_advance && err_ff |=> !err_ff, "error not cleared by recovery")
   `TTEF_ASSERT(a_recovery_counts, s1_advance && err_ff |=> recov_ff == $past(recov_ff) + 32'd1, "recovery not counted")
   `TTEF_ASSERT(a_total_counts, s1_advance |=> total_ff == $past(total_ff) + 32'd1, "trigger not counted")

endmodule

// ----- tb/ttef_event_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for trigger_timestamp_event_formatter: tracks register writes and accepted
// triggers, forms the expected event words and compares every accepted output word.
// Depends on ttef_pkg for register indexes, reset values and the fixed word constants.
module ttef_event_checker
   import ttef_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [15:0]   csr_wdata,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [143:0]  req_tdata,
   input  logic [3:0]    req_tuser,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [127:0]  rsp_tdata,
   input  logic          rsp_tlast,
   input  logic [1:0]    rsp_tuser,
   output int            fail_count,
   output int            outstanding
);

   // one output word with all of its side fields, in the order they are compared
   typedef struct packed {
      logic [31:0] data_word;
      logic        last_word;
      logic        clear_req;
      logic        backwards;
      logic [31:0] type_cnt;
      logic [31:0] total_cnt;
      logic [31:0] recovery_cnt;
   } event_word_type;

   event_word_type pending_words [$];

   // shadow of the block's registers and state
   logic [4:0]  chan_sel;
   logic [15:0] fill_limit;
   logic        error_pending;
   logic [63:0] last_stamp;
   logic [31:0] type_tally [TYPE_COUNT];
   logic [31:0] trigger_tally;
   logic [31:0] recovery_tally;

   // count one trigger and queue the words it must produce
   function automatic void format_trigger(input logic [3:0] trig, input logic [31:0] mask,
                                          input logic [15:0] fill,
                                          input logic [31:0] hi, lo, fine);
      event_word_type w;
      logic [63:0] stamp;
      logic [31:0] tcount;
      tcount = '0;
      trigger_tally = trigger_tally + 1;
      if (trig < TYPE_COUNT) begin
         type_tally[trig] = type_tally[trig] + 1;
         tcount = type_tally[trig];
      end
      w = '0;
      w.type_cnt  = tcount;
      w.total_cnt = trigger_tally;

      // a pending fault turns this trigger into a recovery, whatever its type
      if (error_pending) begin
         recovery_tally = recovery_tally + 1;
         error_pending  = 1'b0;
         w.data_word    = BAD_WORD;
         w.last_word    = 1'b1;
         w.clear_req    = 1'b1;
         w.recovery_cnt = recovery_tally;
         pending_words.push_back(w);
         return;
      end
      w.recovery_cnt = recovery_tally;

      // types 14 and 15 are only counted
      if (trig >= NO_STAMP_TYPE)
         return;

      // channel not ready or FIFO too full: single marker, arm recovery
      if (!mask[chan_sel] || fill > fill_limit) begin
         error_pending = 1'b1;
         w.data_word   = BAD_WORD;
         w.last_word   = 1'b1;
         pending_words.push_back(w);
         return;
      end

      // good trigger: header then four tagged slices, lowest first
      stamp = ({32'b0, hi} << 35) + ({32'b0, lo} << 3) + {61'b0, fine[2:0]};
      w.backwards = last_stamp > stamp;
      last_stamp  = stamp;
      w.data_word = HEADER_WORD;
      pending_words.push_back(w);
      for (int k = 0; k < 4; k++) begin
         w.data_word = {SLICE_ID[k], stamp[16*k +: 16]};
         w.last_word = (k == 3);
         pending_words.push_back(w);
      end
   endfunction

   always @(posedge clock) begin : watch
      event_word_type seen;
      if (reset) begin
         pending_words.delete();
         chan_sel       = FIFO_CHANNEL_RESET;
         fill_limit     = MAX_FILL_RESET;
         error_pending  = 1'b0;
         last_stamp     = '0;
         trigger_tally  = '0;
         recovery_tally = '0;
         for (int i = 0; i < TYPE_COUNT; i++)
            type_tally[i] = '0;
         fail_count = 0;
      end else begin
         // follow register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FIFO_CHANNEL: chan_sel = csr_wdata[4:0];
               CSR_MAX_FILL:     fill_limit = csr_wdata;
               default: ;
            endcase
         end

         // predict each accepted trigger transaction
         if (req_tvalid && req_tready)
            format_trigger(req_tuser, req_tdata[31:0], req_tdata[47:32], req_tdata[79:48],
                           req_tdata[111:80], req_tdata[143:112]);

         // compare each accepted output transaction with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tdata[31:0], rsp_tlast, rsp_tuser[0], rsp_tuser[1],
                    rsp_tdata[63:32], rsp_tdata[95:64], rsp_tdata[127:96]};
            if (pending_words.size() == 0) begin
               fail_count++;
               $display("%0t: expected no word, actual word %h", $time, seen.data_word);
            end else begin
               if (seen !== pending_words[0]) begin
                  fail_count++;
                  $display({"%0t: mismatch\n",
                            "  expected data=%h last=%b clear=%b back=%b type=%0d ",
                            "total=%0d recov=%0d\n",
                            "  actual   data=%h last=%b clear=%b back=%b type=%0d ",
                            "total=%0d recov=%0d"}, $time,
                           pending_words[0].data_word, pending_words[0].last_word,
                           pending_words[0].clear_req, pending_words[0].backwards,
                           pending_words[0].type_cnt, pending_words[0].total_cnt,
                           pending_words[0].recovery_cnt,
                           seen.data_word, seen.last_word, seen.clear_req,
                           seen.backwards, seen.type_cnt, seen.total_cnt,
                           seen.recovery_cnt);
               end
               void'(pending_words.pop_front());
            end
         end
      end
      outstanding <= pending_words.size();
   end

endmodule

// ----- tb/trigger_timestamp_event_formatter_test.sv -----
`timescale 1ns / 100ps
// Testbench top for trigger_timestamp_event_formatter: reset, register writes and
// trigger stimulus with random gaps and output stalls, plus the verdict.
// Depends on ttef_pkg, the RTL and ttef_event_checker, which predicts and compares.
module trigger_timestamp_event_formatter_test;
   import ttef_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 8;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         csr_wr_en  = 1'b0;
   logic         csr_index  = CSR_FIFO_CHANNEL;
   logic [15:0]  csr_wdata  = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata  = '0;
   logic [3:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         rsp_tlast;
   logic [1:0]   rsp_tuser;

   int           fail_count;
   int           outstanding;
   int unsigned  cycle_count = 0;
   int unsigned  drain_stall = 0;
   logic         quiet       = 1'b0;
   logic [4:0]   cur_chan    = FIFO_CHANNEL_RESET;
   logic [15:0]  cur_limit   = MAX_FILL_RESET;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   trigger_timestamp_event_formatter u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   ttef_event_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // stall the output for a random number of cycles after each word
   always @(posedge clock) begin : drain_ctl
      int unsigned n;
      if (reset) begin
         rsp_tready  <= 1'b0;
         drain_stall <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         n = quiet ? 0 : $urandom_range(0, 16);
         drain_stall <= n;
         rsp_tready  <= (n == 0);
      end else if (drain_stall > 1) begin
         drain_stall <= drain_stall - 1;
      end else begin
         drain_stall <= 0;
         rsp_tready  <= 1'b1;
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // present one trigger after a random gap and hold it until accepted
   task automatic send_trigger(input logic [3:0] trig, input logic [31:0] mask,
                               input logic [15:0] fill, input logic [31:0] hi, lo, fine);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= trig;
      req_tdata  <= {fine, lo, hi, fill, mask};
      do @(posedge clock); while (!req_tready);
   endtask

   // hold the input until every expected word is out, then let the block go idle
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both registers on back-to-back cycles
   task automatic write_limits(input logic [4:0] chan, input logic [15:0] limit);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FIFO_CHANNEL;
      csr_wdata <= {11'b0, chan};
      @(posedge clock);
      csr_index <= CSR_MAX_FILL;
      csr_wdata <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_chan  = chan;
      cur_limit = limit;
   endtask

   // mostly passing triggers with random content, some failing the ready or fill check
   task automatic random_phase(input int unsigned count);
      logic [31:0] mask;
      logic [15:0] fill;
      repeat (count) begin
         mask = $urandom;
         if ($urandom_range(0, 7) != 0)
            mask[cur_chan] = 1'b1;
         fill = ($urandom_range(0, 7) != 0) ? 16'($urandom_range(0, cur_limit))
                                             : 16'($urandom);
         send_trigger(4'($urandom_range(0, 15)), mask, fill, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: channel 3, fill limit 1
      send_trigger(4'd0, 32'h0000_0008, 16'd0, 32'd0, 32'd0, 32'd0);
      send_trigger(4'd1, 32'hffff_ffff, 16'd1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      // smaller stamp than the one before: runs backwards
      send_trigger(4'd2, 32'h0000_0008, 16'd0, 32'd0, 32'd1, 32'd0);
      // no-stamp types with nothing pending give no words, even with bad FIFO status
      send_trigger(4'd14, 32'd0, 16'hffff, 32'd0, 32'd0, 32'd0);
      send_trigger(4'd15, 32'd0, 16'hffff, 32'd0, 32'd0, 32'd0);
      // ready bit clear, then recovery on a no-stamp type
      send_trigger(4'd3, 32'hffff_fff7, 16'd0, 32'd5, 32'd5, 32'd5);
      send_trigger(4'd14, 32'hffff_ffff, 16'd0, 32'd0, 32'd0, 32'd0);
      // fill one above the limit, then recovery
      send_trigger(4'd4, 32'hffff_ffff, 16'd2, 32'd7, 32'd7, 32'd7);
      send_trigger(4'd15, 32'hffff_ffff, 16'd0, 32'd0, 32'd0, 32'd0);
      // full fill, then a trigger that would pass but recovers instead
      send_trigger(4'd5, 32'hffff_ffff, 16'hffff, 32'd9, 32'd9, 32'd9);
      send_trigger(4'd6, 32'hffff_ffff, 16'd0, 32'h1000_0000, 32'd0, 32'd0);
      // upper fine bits are ignored
      send_trigger(4'd13, 32'h0000_0008, 16'd1, 32'h1234_5678, 32'h9abc_def0, 32'hffff_fffd);
      for (int t = 7; t <= 12; t++)
         send_trigger(4'(t), 32'h0000_0008, 16'd0, $urandom, $urandom, $urandom);

      // lowest settings: channel 0, no fill allowed
      settle();
      write_limits(5'd0, 16'd0);
      send_trigger(4'd8, 32'h0000_0001, 16'd0, 32'h0000_0001, 32'd0, 32'd3);
      send_trigger(4'd9, 32'h0000_0001, 16'd1, 32'd0, 32'd0, 32'd0);
      send_trigger(4'd10, 32'd0, 16'd0, 32'd0, 32'd0, 32'd0);

      // highest settings: channel 31, any fill
      settle();
      write_limits(5'd31, 16'hffff);
      send_trigger(4'd11, 32'h8000_0000, 16'hffff, 32'hffff_fff0, 32'd0, 32'd0);
      send_trigger(4'd12, 32'h7fff_ffff, 16'd0, 32'd0, 32'd0, 32'd0);
      send_trigger(4'd0, 32'hffff_ffff, 16'd0, 32'd0, 32'd0, 32'd0);

      // random triggers over several settings
      settle();
      write_limits(5'($urandom), 16'($urandom_range(0, 8)));
      random_phase(20);
      settle();
      random_phase(20);

      settle();
      write_limits(5'($urandom), 16'hffff);
      quiet = 1'b1;
      random_phase(15);
      quiet = 1'b0;
      random_phase(10);

      settle();
      write_limits(5'($urandom), 16'($urandom));
      random_phase(20);

      settle();
      write_limits(FIFO_CHANNEL_RESET, MAX_FILL_RESET);
      random_phase(10);

      settle();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
